FILE: rtl/salu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salu_pkg: shared definitions for the signed ALU
// Operation codes and small types of the add/sub/mul/div/rem unit.
// ----------------------------------------------------------------------------
package salu_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ADD = 3'd0;
  localparam kind_t KIND_SUB = 3'd1;
  localparam kind_t KIND_MUL = 3'd2;
  localparam kind_t KIND_DIV = 3'd3;
  localparam kind_t KIND_REM = 3'd4;

endpackage : salu_pkg
`default_nettype wire

FILE: rtl/signed_alu_mul_div_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_alu_mul_div_mod_unit: signed add, subtract, multiply, divide, remainder
//
// Input channel (in_valid_i/in_ready_o) carries one request: kind_i and two
// signed DATA_WIDTH-bit operands. Output channel (out_valid_o/out_ready_i)
// returns result_o and divide_by_zero_o for each request, in order.
// Add and subtract: acceptance loads the operands, then the fix-up state
// writes the sum or difference from the shared adder to the output register.
// Multiply, divide and remainder: acceptance loads the operand magnitudes,
// then DATA_WIDTH steps of the shared adder (one shift-add or one restoring
// subtract per bit) and a sign fix-up state that writes the output register.
// The unit holds one request at a time; in_ready_o is high only while the
// sequencer is idle, so a new request is accepted only once the previous one
// has left the fix-up state. Results go into an output register, so a new
// request is accepted while the previous result still waits. If the receiver
// stalls and the output register is full, the sequencer holds in its
// fix-up state until the register frees up.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module signed_alu_mul_div_mod_unit
  import salu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [2:0]                   kind_i,
  input  wire logic signed [DATA_WIDTH-1:0] left_operand_i,
  input  wire logic signed [DATA_WIDTH-1:0] right_operand_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic signed [DATA_WIDTH-1:0] result_o,
  output      logic                         divide_by_zero_o
);

  localparam int W    = DATA_WIDTH;
  localparam int CNTW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_e;

  state_e          state_q, state_d;
  kind_t           kind_q, kind_d;
  logic [W-1:0]    a_q, a_d;     // addend, multiplicand, or dividend/quotient
  logic [W-1:0]    b_q, b_d;     // addend, multiplier, or divisor
  logic [W-1:0]    acc_q, acc_d; // product or partial remainder
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            dz_q, dz_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    result_q, result_d;
  logic            dz_out_q, dz_out_d;

  // Shared adder: x + (sub ? ~y + 1 : y), with carry out on top
  logic [W:0]   add_x, add_y;
  logic         add_sub;
  logic [W+1:0] add_sum;

  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + {{(W+1){1'b0}}, add_sub};

  logic in_fire;
  logic a_neg, b_neg, seq_op;
  logic [W-1:0] a_mag, b_mag;
  logic [W-1:0] rem_shift;
  logic         rem_top;
  logic         div_ge;
  logic [W-1:0] fix_val;
  logic         fix_write;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Operand magnitudes at load time
  assign a_neg  = left_operand_i[W-1];
  assign b_neg  = right_operand_i[W-1];
  assign a_mag  = a_neg ? (~left_operand_i + W'(1)) : left_operand_i;
  assign b_mag  = b_neg ? (~right_operand_i + W'(1)) : right_operand_i;
  assign seq_op = kind_i inside {KIND_MUL, KIND_DIV, KIND_REM};

  // Restoring division step: shift in next dividend bit, trial subtract
  assign rem_top   = acc_q[W-1];
  assign rem_shift = {acc_q[W-2:0], a_q[W-1]};
  assign div_ge    = add_sum[W+1];

  // Value to sign-fix at the end of a sequenced operation
  always_comb begin
    case (kind_q)
      KIND_DIV: fix_val = a_q;
      default:  fix_val = acc_q;
    endcase
  end

  // Drive shared adder operands
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    if (state_q == ST_RUN) begin
      if (kind_q == KIND_MUL) begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, a_q};
      end else begin
        add_x   = {rem_top, rem_shift};
        add_y   = {1'b0, b_q};
        add_sub = 1'b1;
      end
    end else if (kind_q inside {KIND_ADD, KIND_SUB}) begin
      add_x   = {1'b0, a_q};
      add_y   = {1'b0, b_q};
      add_sub = (kind_q == KIND_SUB);
    end else begin
      add_y   = {1'b0, fix_val};
      add_sub = neg_q;
    end
  end

  assign fix_write = (state_q == ST_FIX) && (!out_valid_q || out_ready_i);

  // Sequencer and output register next state
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    dz_d        = dz_q;
    result_d    = result_q;
    dz_out_d    = dz_out_q;
    out_valid_d = out_valid_q;

    // drop the held result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d = kind_i;
          acc_d  = '0;
          cnt_d  = CNT_LAST;
          dz_d   = (kind_i inside {KIND_DIV, KIND_REM}) && (right_operand_i == '0);
          neg_d  = (kind_i == KIND_REM) ? a_neg : (a_neg ^ b_neg);
          if (seq_op) begin
            a_d     = a_mag;
            b_d     = b_mag;
            state_d = ST_RUN;
          end else begin
            a_d     = left_operand_i;
            b_d     = right_operand_i;
            state_d = ST_FIX;
          end
        end
      end
      ST_RUN: begin
        if (kind_q == KIND_MUL) begin
          // accumulate shifted multiplicand when multiplier bit is set
          acc_d = b_q[0] ? add_sum[W-1:0] : acc_q;
          a_d   = {a_q[W-2:0], 1'b0};
          b_d   = {1'b0, b_q[W-1:1]};
        end else begin
          // keep difference when it fits, shift quotient bit in
          acc_d = div_ge ? add_sum[W-1:0] : rem_shift;
          a_d   = {a_q[W-2:0], div_ge};
        end
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        // hold here while output register is still full
        if (fix_write) begin
          case (kind_q)
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_REM: begin
              result_d = add_sum[W-1:0];
            end
            default: result_d = '0;
          endcase
          dz_out_d    = dz_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_ADD;
      a_q         <= '0;
      b_q         <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      dz_q        <= 1'b0;
      result_q    <= '0;
      dz_out_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      a_q         <= a_d;
      b_q         <= b_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      dz_q        <= dz_d;
      result_q    <= result_d;
      dz_out_q    <= dz_out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = result_q;
  assign divide_by_zero_o = dz_out_q;

  // Assertions
  a_run_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !in_ready_o)
    else $error("accepting a request while the sequencer runs");

  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted request did not start the sequencer");

  a_full_holds_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIX) && out_valid_q && !out_ready_i) |=>
      ((state_q == ST_FIX) && $stable(result_q)))
    else $error("result written over an untaken result");

  a_dz_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fix_write && dz_q) |-> ((kind_q == KIND_DIV) || (kind_q == KIND_REM)))
    else $error("zero-divisor flag on a non-divide request");

endmodule : signed_alu_mul_div_mod_unit
`default_nettype wire
